### sv/calibrated_line_sensor_steering_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line sensor steering unit
// Concurrent property wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CALIBRATED_LINE_SENSOR_STEERING_UNIT_ASSERT_SVH
`define CALIBRATED_LINE_SENSOR_STEERING_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CLSU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clsu assertion failed");
`define CLSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clsu assertion failed");
`else
`define CLSU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CLSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### sv/clsu_pkg.sv
// ----------------------------------------------------------------------------
// Line sensor steering package
// Shared widths, register indexes, drive codes and result type.
// ----------------------------------------------------------------------------
package clsu_pkg;

  localparam int THRESH_W   = 10;
  localparam int LEN_W      = 8;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd300;
  localparam logic [LEN_W-1:0]    LEN_RESET    = 8'd100;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_LENGTH     = 1'b1;

  typedef enum logic [1:0] {
    CMD_FORWARD = 2'd0,
    CMD_LEFT    = 2'd1,
    CMD_RIGHT   = 2'd2,
    CMD_STOP    = 2'd3
  } drive_cmd_e;

  typedef struct packed {
    logic       done;
    logic       left;
    logic       centre;
    logic       right;
    drive_cmd_e cmd;
  } result_t;

endpackage

### sv/clsu_if.sv
// ----------------------------------------------------------------------------
// Line sensor steering channels
// Sample input, result output and register write channels.
// ----------------------------------------------------------------------------
interface clsu_in_if #(parameter int SAMPLE_BITS = 10) ();
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [SAMPLE_BITS-1:0] left_sample;
  logic [SAMPLE_BITS-1:0] centre_sample;
  logic [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, op, left_sample, centre_sample, right_sample,
                  input ready);
  modport sink   (input valid, op, left_sample, centre_sample, right_sample,
                  output ready);
endinterface

interface clsu_out_if ();
  logic       valid;
  logic       ready;
  logic       calibration_done;
  logic       left_on_line;
  logic       centre_on_line;
  logic       right_on_line;
  logic [1:0] drive_command;

  modport source (output valid, calibration_done, left_on_line, centre_on_line,
                  right_on_line, drive_command, input ready);
  modport sink   (input valid, calibration_done, left_on_line, centre_on_line,
                  right_on_line, drive_command, output ready);
endinterface

interface clsu_cfg_if #(parameter int IDX_W = 1, parameter int DATA_W = 10) ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### sv/calibrated_line_sensor_steering_unit.sv
// ----------------------------------------------------------------------------
// Calibrated line sensor steering unit
// Running-average bias calibration and bang-bang steering for three sensors.
// ----------------------------------------------------------------------------
// A steer item, or a calibrate item once calibration is complete, is answered
// through the pending register and then the output register. A calibrate item
// that updates the biases runs six divisions by the sample count through one
// restoring divider, one quotient bit per cycle; input ready stays low until
// its result has gone to the output register. One result waits in an
// output register, so the next item may be taken before it is collected.
// Register writes are always taken.
`include "calibrated_line_sensor_steering_unit_assert.svh"

module calibrated_line_sensor_steering_unit
  import clsu_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  clsu_in_if.sink    in_i,
  clsu_out_if.source res_o,
  clsu_cfg_if.sink   cfg_i
);

  localparam int CW = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
  localparam logic [2:0] LAST_DIV = 3'd5;

  typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_FINISH} state_e;

  state_e                 state_q, state_d;
  logic [2:0]             k_q, k_d;
  logic [LEN_W-1:0]       cnt_q, cnt_d, len_q;
  logic [THRESH_W-1:0]    thr_q;
  logic                   out_valid_q, out_valid_d;
  result_t                out_q, pend_q, pend_d, steer_res;
  logic [SAMPLE_BITS-1:0] lb_q, cb_q, rb_q;
  logic [SAMPLE_BITS-1:0] ls_q, cs_q, rs_q;
  logic [SAMPLE_BITS-1:0] qb_q;
  logic [SAMPLE_BITS-1:0] dividend, bias_sel, quotient, bias_new;
  logic [SAMPLE_BITS:0]   blend;
  logic                   in_xfer, done_now, div_start, div_done, load_out;

  function automatic logic sees(logic [SAMPLE_BITS-1:0] s, logic [SAMPLE_BITS-1:0] b,
                                logic [THRESH_W-1:0] t);
    logic [CW-1:0] a, c, th;
    a  = CW'(s);
    c  = CW'(b);
    th = CW'(t);
    return (a >= c) && ((a - c) >= th);
  endfunction

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign done_now    = cnt_q >= len_q;
  assign div_start   = (state_q == S_START);

  clsu_div #(.W(SAMPLE_BITS), .DW(LEN_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    steer_res.done   = done_now;
    steer_res.left   = sees(in_i.left_sample, lb_q, thr_q);
    steer_res.centre = sees(in_i.centre_sample, cb_q, thr_q);
    steer_res.right  = sees(in_i.right_sample, rb_q, thr_q);
    if (steer_res.centre)      steer_res.cmd = CMD_FORWARD;
    else if (steer_res.left)   steer_res.cmd = CMD_LEFT;
    else if (steer_res.right)  steer_res.cmd = CMD_RIGHT;
    else                       steer_res.cmd = CMD_STOP;
  end

  always_comb begin
    case (k_q[2:1])
      2'd0:    bias_sel = lb_q;
      2'd1:    bias_sel = cb_q;
      default: bias_sel = rb_q;
    endcase
    case (k_q)
      3'd0:    dividend = lb_q;
      3'd1:    dividend = ls_q;
      3'd2:    dividend = cb_q;
      3'd3:    dividend = cs_q;
      3'd4:    dividend = rb_q;
      default: dividend = rs_q;
    endcase
    blend    = {1'b0, bias_sel} - {1'b0, qb_q} + {1'b0, quotient};
    bias_new = blend[SAMPLE_BITS] ? '1 : blend[SAMPLE_BITS-1:0];
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !res_o.ready;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_i.op) begin
            pend_d  = steer_res;
            state_d = S_FINISH;
          end else begin
            pend_d = '{done: done_now, left: 1'b0, centre: 1'b0, right: 1'b0,
                       cmd: CMD_STOP};
            if (done_now) begin
              state_d = S_FINISH;
            end else begin
              cnt_d   = cnt_q + LEN_W'(1);
              k_d     = '0;
              state_d = S_START;
            end
          end
        end
      end
      S_START: state_d = S_WAIT;
      S_WAIT: begin
        if (div_done) begin
          if (k_q == LAST_DIV) begin
            state_d = S_FINISH;
          end else begin
            k_d     = k_q + 3'd1;
            state_d = S_START;
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_q || res_o.ready) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      thr_q       <= THRESH_RESET;
      len_q       <= LEN_RESET;
      lb_q        <= '0;
      cb_q        <= '0;
      rb_q        <= '0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (load_out) out_q <= pend_q;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_LINE_THRESHOLD: thr_q <= cfg_i.data[THRESH_W-1:0];
          REG_CAL_LENGTH:     len_q <= cfg_i.data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (state_q == S_WAIT && div_done && k_q[0]) begin
        case (k_q[2:1])
          2'd0:    lb_q <= bias_new;
          2'd1:    cb_q <= bias_new;
          default: rb_q <= bias_new;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (in_xfer) begin
      ls_q <= in_i.left_sample;
      cs_q <= in_i.centre_sample;
      rs_q <= in_i.right_sample;
    end
    if (state_q == S_WAIT && div_done && !k_q[0]) qb_q <= quotient;
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.calibration_done = out_q.done;
  assign res_o.left_on_line     = out_q.left;
  assign res_o.centre_on_line   = out_q.centre;
  assign res_o.right_on_line    = out_q.right;
  assign res_o.drive_command    = out_q.cmd;

  `CLSU_ASSERT_NEXT(a_cnt_step, clk_i, rst_ni, in_xfer && !in_i.op && !done_now,
                    cnt_q == $past(cnt_q) + LEN_W'(1))
  `CLSU_ASSERT_SAME(a_div_wait, clk_i, rst_ni, div_done, state_q == S_WAIT)
  `CLSU_ASSERT_NEXT(a_finish_out, clk_i, rst_ni, state_q == S_FINISH && !out_valid_q,
                    res_o.valid)

endmodule

### sv/clsu_div.sv
// ----------------------------------------------------------------------------
// Line sensor steering divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module clsu_div #(
  parameter int W  = 10,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [W-1:0]  quotient_o
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    rem_q, rem_d, divisor_q;
  logic [W-1:0]     quo_q;
  logic [DW:0]      shifted, diff;
  logic             fits;

  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = shifted - {1'b0, divisor_q};
    fits    = shifted >= {1'b0, divisor_q};
    rem_d   = fits ? diff[DW-1:0] : shifted[DW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
